FILE: hw/rtl/ers_pkg.sv
// ----------------------------------------------------------------------------
// ers_pkg
// shared types and codes for the elevator request scheduler
// ----------------------------------------------------------------------------
package ers_pkg;

    localparam int COUNT_BITS     = 5;
    localparam int STATUS_BITS    = 3;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOWEST   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGHEST  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CAPACITY = 2'd2;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_GO      = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK      = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_UP      = 3'd2,
        STAT_DOWN    = 3'd3,
        STAT_NOFLOOR = 3'd4,
        STAT_IDLE    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        SCAN_INSERT,
        SCAN_SEEK_UP,
        SCAN_SEEK_DOWN,
        SCAN_DROP
    } scan_kind_t;

    typedef struct packed {
        logic                  active;
        scan_kind_t            kind;
        logic                  hit;
        logic [COUNT_BITS-1:0] count;
    } scan_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_SEEK,
        S_DROP,
        S_DONE
    } seq_state_t;

endpackage

FILE: hw/rtl/ers_cell.sv
// ----------------------------------------------------------------------------
// ers_cell
// one request slot of the scan chain; acts on the token passing through
// ----------------------------------------------------------------------------
module ers_cell
    import ers_pkg::*;
#(
    parameter int FLOOR_BITS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  scan_ctl_t                    ctl_in,
    input  logic signed [FLOOR_BITS-1:0] val_in,
    output scan_ctl_t                    ctl_out,
    output logic signed [FLOOR_BITS-1:0] val_out
);

    logic                         slot_valid_reg;
    logic                         slot_valid_next;
    logic signed [FLOOR_BITS-1:0] slot_floor_reg;
    logic signed [FLOOR_BITS-1:0] slot_floor_next;
    scan_ctl_t                    ctl_out_reg;
    scan_ctl_t                    ctl_out_next;
    logic signed [FLOOR_BITS-1:0] val_out_reg;
    logic signed [FLOOR_BITS-1:0] val_out_next;

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        slot_floor_next = slot_floor_reg;
        ctl_out_next    = ctl_in;
        val_out_next    = val_in;
        if (ctl_in.active)
        begin
            case (ctl_in.kind)
                SCAN_INSERT:
                begin
                    // first free slot takes the pending floor
                    if (ctl_in.hit && !slot_valid_reg)
                    begin
                        slot_valid_next  = 1'b1;
                        slot_floor_next  = val_in;
                        ctl_out_next.hit = 1'b0;
                    end
                end
                SCAN_SEEK_UP:
                begin
                    if (slot_valid_reg && (!ctl_in.hit || slot_floor_reg < val_in))
                    begin
                        val_out_next     = slot_floor_reg;
                        ctl_out_next.hit = 1'b1;
                    end
                end
                SCAN_SEEK_DOWN:
                begin
                    if (slot_valid_reg && (!ctl_in.hit || slot_floor_reg > val_in))
                    begin
                        val_out_next     = slot_floor_reg;
                        ctl_out_next.hit = 1'b1;
                    end
                end
                SCAN_DROP:
                begin
                    if (slot_valid_reg && slot_floor_reg == val_in)
                    begin
                        slot_valid_next    = 1'b0;
                        ctl_out_next.count = ctl_in.count + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            ctl_out_reg    <= '0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            ctl_out_reg    <= ctl_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_floor_reg <= slot_floor_next;
        val_out_reg    <= val_out_next;
    end

    assign ctl_out = ctl_out_reg;
    assign val_out = val_out_reg;

endmodule

FILE: hw/rtl/elevator_request_scheduler.sv
// ----------------------------------------------------------------------------
// elevator_request_scheduler
// scan-order elevator scheduler built on a chain of request slot cells
// an accepted request makes an insert pass through the chain, a go a seek pass
// then a drop pass; a rejected request or an idle go skips the chain;
// one item in flight at a time
// reset: all slots free, car at floor 0 heading up, config registers to defaults
// ----------------------------------------------------------------------------
module elevator_request_scheduler
    import ers_pkg::*;
#(
    parameter  int MAX_LOAD   = 16,
    parameter  int FLOOR_BITS = 8,
    localparam int IN_BITS    = ((FLOOR_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = ((FLOOR_BITS + STATUS_BITS + 3 * COUNT_BITS - 4 + 7) / 8) * 8,
    localparam int CFG_BITS   = (FLOOR_BITS > COUNT_BITS) ? FLOOR_BITS : COUNT_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_BITS-1:0]        s_tdata,   // floor
    input  logic [0:0]                s_tuser,   // operation
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_BITS-1:0]       m_tdata,   // status, floor_now, load, heading_down, left_car
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
    localparam logic [COUNT_BITS-1:0] LOAD_LIMIT =
        (MAX_LOAD > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(MAX_LOAD);
    localparam int HIGH_DEFAULT = (FLOOR_BITS >= 5) ? 15 : (1 << (FLOOR_BITS - 1)) - 1;

    scan_ctl_t                    ctl_link [0:MAX_LOAD];
    logic signed [FLOOR_BITS-1:0] val_link [0:MAX_LOAD];
    logic [MAX_LOAD:0]            token_live;

    logic signed [FLOOR_BITS-1:0] lowest_reg;
    logic signed [FLOOR_BITS-1:0] highest_reg;
    logic [COUNT_BITS-1:0]        capacity_reg;

    seq_state_t                   state_reg;
    seq_state_t                   state_next;
    logic signed [FLOOR_BITS-1:0] car_floor_reg;
    logic signed [FLOOR_BITS-1:0] car_floor_next;
    logic [COUNT_BITS-1:0]        rider_reg;
    logic [COUNT_BITS-1:0]        rider_next;
    logic                         down_reg;
    logic                         down_next;
    scan_ctl_t                    inj_ctl_reg;
    scan_ctl_t                    inj_ctl_next;
    logic signed [FLOOR_BITS-1:0] inj_val_reg;
    logic signed [FLOOR_BITS-1:0] inj_val_next;
    status_t                      res_status_reg;
    status_t                      res_status_next;
    logic [COUNT_BITS-1:0]        res_left_reg;
    logic [COUNT_BITS-1:0]        res_left_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [OUT_BITS-1:0]          out_data_reg;
    logic [OUT_BITS-1:0]          out_data_next;

    logic signed [FLOOR_BITS-1:0] req_floor;
    logic [COUNT_BITS-1:0]        cap_eff;
    scan_ctl_t                    tail_ctl;
    logic signed [FLOOR_BITS-1:0] tail_val;

    assign ctl_link[0] = inj_ctl_reg;
    assign val_link[0] = inj_val_reg;
    assign tail_ctl    = ctl_link[MAX_LOAD];
    assign tail_val    = val_link[MAX_LOAD];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LOAD; gi++)
        begin : g_cell
            ers_cell #(
                .FLOOR_BITS (FLOOR_BITS)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl_in  (ctl_link[gi]),
                .val_in  (val_link[gi]),
                .ctl_out (ctl_link[gi+1]),
                .val_out (val_link[gi+1])
            );
        end
        for (gi = 0; gi <= MAX_LOAD; gi++)
        begin : g_live
            assign token_live[gi] = ctl_link[gi].active;
        end
    endgenerate

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg   <= '0;
            highest_reg  <= FLOOR_BITS'(HIGH_DEFAULT);
            capacity_reg <= COUNT_BITS'(8);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LOWEST:   lowest_reg   <= cfg_data[FLOOR_BITS-1:0];
                CFG_HIGHEST:  highest_reg  <= cfg_data[FLOOR_BITS-1:0];
                CFG_CAPACITY: capacity_reg <= cfg_data[COUNT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign req_floor = s_tdata[FLOOR_BITS-1:0];
    assign cap_eff   = (capacity_reg < LOAD_LIMIT) ? capacity_reg : LOAD_LIMIT;
    assign s_tready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        car_floor_next  = car_floor_reg;
        rider_next      = rider_reg;
        down_next       = down_reg;
        inj_ctl_next    = '0;
        inj_val_next    = inj_val_reg;
        res_status_next = res_status_reg;
        res_left_next   = res_left_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_left_next = '0;
                    state_next    = S_DONE;
                    if (s_tuser[0] == OP_GO)
                    begin
                        if (rider_reg == '0)
                        begin
                            res_status_next = STAT_IDLE;
                        end
                        else
                        begin
                            res_status_next     = STAT_OK;
                            inj_ctl_next.active = 1'b1;
                            inj_ctl_next.kind   = down_reg ? SCAN_SEEK_DOWN : SCAN_SEEK_UP;
                            state_next          = S_SEEK;
                        end
                    end
                    else if (rider_reg >= cap_eff)
                    begin
                        res_status_next = STAT_FULL;
                    end
                    else if (rider_reg != '0 && !down_reg && req_floor < car_floor_reg)
                    begin
                        res_status_next = STAT_UP;
                    end
                    else if (rider_reg != '0 && down_reg && req_floor > car_floor_reg)
                    begin
                        res_status_next = STAT_DOWN;
                    end
                    else if (req_floor > highest_reg || req_floor < lowest_reg)
                    begin
                        res_status_next = STAT_NOFLOOR;
                    end
                    else
                    begin
                        res_status_next = STAT_OK;
                        // empty car takes its heading from the first request
                        if (rider_reg == '0)
                        begin
                            if (req_floor > car_floor_reg)
                            begin
                                down_next = 1'b0;
                            end
                            else if (req_floor < car_floor_reg)
                            begin
                                down_next = 1'b1;
                            end
                        end
                        rider_next          = rider_reg + 1'b1;
                        inj_ctl_next.active = 1'b1;
                        inj_ctl_next.kind   = SCAN_INSERT;
                        inj_ctl_next.hit    = 1'b1;
                        inj_val_next        = req_floor;
                        state_next          = S_INSERT;
                    end
                end
            end
            S_INSERT:
            begin
                if (tail_ctl.active)
                begin
                    state_next = S_DONE;
                end
            end
            S_SEEK:
            begin
                if (tail_ctl.active)
                begin
                    car_floor_next      = tail_val;
                    inj_ctl_next.active = 1'b1;
                    inj_ctl_next.kind   = SCAN_DROP;
                    inj_val_next        = tail_val;
                    state_next          = S_DROP;
                end
            end
            S_DROP:
            begin
                if (tail_ctl.active)
                begin
                    rider_next    = (rider_reg >= tail_ctl.count) ?
                                    rider_reg - tail_ctl.count : '0;
                    res_left_next = tail_ctl.count;
                    // turn around at the ends of the shaft
                    if (car_floor_reg == highest_reg)
                    begin
                        down_next = 1'b1;
                    end
                    else if (car_floor_reg == lowest_reg)
                    begin
                        down_next = 1'b0;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_BITS'({res_left_reg, down_reg, rider_reg,
                                                car_floor_reg, res_status_reg});
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            car_floor_reg <= '0;
            rider_reg     <= '0;
            down_reg      <= 1'b0;
            inj_ctl_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            car_floor_reg <= car_floor_next;
            rider_reg     <= rider_next;
            down_reg      <= down_next;
            inj_ctl_reg   <= inj_ctl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inj_val_reg    <= inj_val_next;
        res_status_reg <= res_status_next;
        res_left_reg   <= res_left_reg == res_left_next ? res_left_reg : res_left_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // at most one token travels the chain
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(token_live))
        else $error("more than one scan token in the chain");

    // a token only comes back while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        tail_ctl.active |-> (state_reg == S_INSERT || state_reg == S_SEEK ||
                             state_reg == S_DROP))
        else $error("scan token returned outside a wait state");

    // an accepted request always finds a free slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (tail_ctl.active && tail_ctl.kind == SCAN_INSERT) |-> !tail_ctl.hit)
        else $error("request token left the chain unplaced");

    // a seek is only launched with riders aboard, so it finds a stop
    assert property (@(posedge clk) disable iff (!rst_n)
        (tail_ctl.active && (tail_ctl.kind == SCAN_SEEK_UP ||
                             tail_ctl.kind == SCAN_SEEK_DOWN)) |-> tail_ctl.hit)
        else $error("seek token found no stored floor");

endmodule
